[hdl/assert_macros.svh]
// Assertion helpers for the heap queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define IHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that an implication holds on every clock edge outside reset
`define IHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/ihq_pkg.sv]
// ----------------------------------------------------------------------------
// ihq_pkg
// Types and constants shared by the indexed max-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none
package ihq_pkg;

  localparam int KEY_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int OP_W  = 3;
  localparam int ST_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MODIFY = 3'd2,
    OP_POP    = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_POS, S_RM, S_P1, S_P2, S_LK, S_CLR,
    S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_L, S_DN_R, S_TOP_RD, S_TOP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  function automatic logic val_less(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage
`default_nettype wire

[hdl/ihq_ram.sv]
// ----------------------------------------------------------------------------
// ihq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ihq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/indexed_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Binary max-heap of (key, value) entries with a key-to-position map.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | op, entry_key, entry_value
//  out_    | master    | status, found, result_key, result_value, top_key,
//          |           | top_value, entry_count, is_empty
//
// One request at a time; each sift-up and sift-down level is paced by the single heap
// memory read port. Clear reads every entry to zero its slot in the position map.
// After reset the position map is swept to zero, one key at a time.
// A result waiting on out_tready holds the next request at its last step.
`default_nettype none
`include "assert_macros.svh"
module indexed_max_heap_queue #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_SPACE = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // op[2:0], entry_key[12:3], entry_value[44:13]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [103:0] out_tdata   // status[2:0], found[3], result_key[13:4],
                                        // result_value[45:14], top_key[55:46],
                                        // top_value[87:56], entry_count[98:88],
                                        // is_empty[99]
);

  localparam int HA = $clog2(CAPACITY + 1);
  localparam int PA = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
  localparam int EW = ihq_pkg::KEY_W + ihq_pkg::VAL_W;

  ihq_pkg::state_t state_r, state_nxt;
  logic [ihq_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [ihq_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [ihq_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic [HA-1:0]              cnt_r, cnt_nxt;
  logic [HA-1:0]              k_r, k_nxt;
  logic [PA-1:0]              idx_r, idx_nxt;
  ihq_pkg::entry_t            e_r, e_nxt, left_r, left_nxt, res_r, res_nxt;
  logic                       moved_r, moved_nxt, uponly_r, uponly_nxt;
  logic                       found_r, found_nxt;
  ihq_pkg::status_t           status_r, status_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [103:0]               out_data_r, out_data_nxt;

  logic          hw_en, hr_en, pw_en;
  logic [HA-1:0] hw_addr, hr_addr, pw_data;
  logic [EW-1:0] hw_data, h_rdata;
  logic [PA-1:0] pw_addr;
  logic [HA-1:0] p_rdata;

  ihq_pkg::entry_t hrd, child;
  logic [HA-1:0]   child_idx;
  logic [HA:0]     k2, cnt_x;
  logic            key_ok;
  logic [ihq_pkg::VAL_W-1:0] top_v;
  logic [ihq_pkg::KEY_W-1:0] top_k;

  ihq_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1)) u_heap (
    .clk(clk), .we(hw_en), .waddr(hw_addr), .wdata(hw_data),
    .re(hr_en), .raddr(hr_addr), .rdata(h_rdata)
  );

  ihq_ram #(.WIDTH(HA), .DEPTH(KEY_SPACE)) u_pos (
    .clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
    .re(in_tvalid && in_tready), .raddr(PA'(in_tdata[12:3])), .rdata(p_rdata)
  );

  assign in_tready  = (state_r == ihq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign hrd    = ihq_pkg::entry_t'(h_rdata);
  assign k2     = {k_r, 1'b0};
  assign cnt_x  = (HA+1)'(cnt_r);
  assign key_ok = (17'(key_r) < 17'(KEY_SPACE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ihq_pkg::S_INIT;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    k_r        <= k_nxt;
    e_r        <= e_nxt;
    left_r     <= left_nxt;
    res_r      <= res_nxt;
    moved_r    <= moved_nxt;
    uponly_r   <= uponly_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    e_nxt         = e_r;
    left_nxt      = left_r;
    res_nxt       = res_r;
    moved_nxt     = moved_r;
    uponly_nxt    = uponly_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    hw_en   = 1'b0;
    hw_addr = k_r;
    hw_data = e_r;
    hr_en   = 1'b0;
    hr_addr = '0;
    pw_en   = 1'b0;
    pw_addr = PA'(e_r.key);
    pw_data = k_r;
    child     = left_r;
    child_idx = HA'(k2);
    top_k = '0;
    top_v = '0;

    unique case (state_r)
      ihq_pkg::S_INIT: begin
        pw_en   = 1'b1;
        pw_addr = idx_r;
        pw_data = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == PA'(KEY_SPACE - 1)) begin
          state_nxt = ihq_pkg::S_IDLE;
        end
      end

      ihq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tdata[2:0];
          key_nxt    = in_tdata[12:3];
          val_nxt    = in_tdata[44:13];
          moved_nxt  = 1'b0;
          uponly_nxt = 1'b0;
          status_nxt = ihq_pkg::ST_OK;
          found_nxt  = 1'b0;
          res_nxt    = '0;
          state_nxt  = ihq_pkg::S_POS;
        end
      end

      ihq_pkg::S_POS: begin
        state_nxt = ihq_pkg::S_TOP_RD;
        e_nxt     = '{key: key_r, value: val_r};
        k_nxt     = p_rdata;
        if (op_r <= 3'(ihq_pkg::OP_MODIFY) || op_r == 3'(ihq_pkg::OP_LOOKUP)) begin
          found_nxt = key_ok && (p_rdata != '0);
        end
        case (op_r)
          ihq_pkg::OP_INSERT: begin
            if (!key_ok) begin
              status_nxt = ihq_pkg::ST_NOTFOUND;
            end else if (p_rdata != '0) begin
              status_nxt = ihq_pkg::ST_DUP;
            end else if (32'(cnt_r) >= 32'(CAPACITY)) begin
              status_nxt = ihq_pkg::ST_FULL;
            end else begin
              cnt_nxt    = cnt_r + 1'b1;
              k_nxt      = cnt_r + 1'b1;
              uponly_nxt = 1'b1;
              state_nxt  = ihq_pkg::S_UP_RD;
            end
          end
          ihq_pkg::OP_REMOVE: begin
            if (!key_ok || p_rdata == '0) begin
              status_nxt = ihq_pkg::ST_NOTFOUND;
            end else begin
              pw_en   = 1'b1;
              pw_addr = PA'(key_r);
              pw_data = '0;
              if (p_rdata == cnt_r) begin
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                hr_en     = 1'b1;
                hr_addr   = cnt_r;
                state_nxt = ihq_pkg::S_RM;
              end
            end
          end
          ihq_pkg::OP_MODIFY: begin
            if (!key_ok || p_rdata == '0) begin
              status_nxt = ihq_pkg::ST_NOTFOUND;
            end else begin
              state_nxt = ihq_pkg::S_UP_RD;
            end
          end
          ihq_pkg::OP_POP: begin
            if (cnt_r == '0) begin
              status_nxt = ihq_pkg::ST_EMPTY;
            end else begin
              hr_en     = 1'b1;
              hr_addr   = HA'(1);
              state_nxt = ihq_pkg::S_P1;
            end
          end
          ihq_pkg::OP_LOOKUP: begin
            if (!key_ok || p_rdata == '0) begin
              status_nxt = ihq_pkg::ST_NOTFOUND;
            end else begin
              hr_en     = 1'b1;
              hr_addr   = p_rdata;
              state_nxt = ihq_pkg::S_LK;
            end
          end
          ihq_pkg::OP_CLEAR: begin
            k_nxt = HA'(1);
            if (cnt_r != '0) begin
              hr_en     = 1'b1;
              hr_addr   = HA'(1);
              state_nxt = ihq_pkg::S_CLR;
            end
          end
          default: ;
        endcase
      end

      ihq_pkg::S_RM: begin
        // move the last entry into the hole and re-sift it
        e_nxt     = hrd;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = ihq_pkg::S_UP_RD;
      end

      ihq_pkg::S_P1: begin
        res_nxt   = hrd;
        hr_en     = 1'b1;
        hr_addr   = cnt_r;
        state_nxt = ihq_pkg::S_P2;
      end

      ihq_pkg::S_P2: begin
        e_nxt   = hrd;
        pw_en   = 1'b1;
        pw_addr = PA'(res_r.key);
        pw_data = '0;
        cnt_nxt = cnt_r - 1'b1;
        k_nxt   = HA'(1);
        state_nxt = (cnt_r == HA'(1)) ? ihq_pkg::S_TOP_RD : ihq_pkg::S_DN_RD;
      end

      ihq_pkg::S_LK: begin
        res_nxt   = '{key: key_r, value: hrd.value};
        state_nxt = ihq_pkg::S_TOP_RD;
      end

      ihq_pkg::S_CLR: begin
        pw_en   = 1'b1;
        pw_addr = PA'(hrd.key);
        pw_data = '0;
        if (k_r == cnt_r) begin
          cnt_nxt   = '0;
          state_nxt = ihq_pkg::S_TOP_RD;
        end else begin
          k_nxt   = k_r + 1'b1;
          hr_en   = 1'b1;
          hr_addr = k_r + 1'b1;
        end
      end

      ihq_pkg::S_UP_RD: begin
        if (k_r == HA'(1)) begin
          if (uponly_r || moved_r) begin
            hw_en     = 1'b1;
            pw_en     = 1'b1;
            state_nxt = ihq_pkg::S_TOP_RD;
          end else begin
            state_nxt = ihq_pkg::S_DN_RD;
          end
        end else begin
          hr_en     = 1'b1;
          hr_addr   = k_r >> 1;
          state_nxt = ihq_pkg::S_UP_CMP;
        end
      end

      ihq_pkg::S_UP_CMP: begin
        if (ihq_pkg::val_less(hrd.value, e_r.value)) begin
          // pull the parent down into the hole
          hw_en     = 1'b1;
          hw_data   = hrd;
          pw_en     = 1'b1;
          pw_addr   = PA'(hrd.key);
          k_nxt     = k_r >> 1;
          moved_nxt = 1'b1;
          state_nxt = ihq_pkg::S_UP_RD;
        end else if (uponly_r || moved_r) begin
          hw_en     = 1'b1;
          pw_en     = 1'b1;
          state_nxt = ihq_pkg::S_TOP_RD;
        end else begin
          state_nxt = ihq_pkg::S_DN_RD;
        end
      end

      ihq_pkg::S_DN_RD: begin
        if (k2 > cnt_x) begin
          hw_en     = 1'b1;
          pw_en     = 1'b1;
          state_nxt = ihq_pkg::S_TOP_RD;
        end else begin
          hr_en     = 1'b1;
          hr_addr   = HA'(k2);
          state_nxt = ihq_pkg::S_DN_L;
        end
      end

      ihq_pkg::S_DN_L, ihq_pkg::S_DN_R: begin
        left_nxt = hrd;
        if (state_r == ihq_pkg::S_DN_L && k2 < cnt_x) begin
          hr_en     = 1'b1;
          hr_addr   = HA'(k2) + 1'b1;
          state_nxt = ihq_pkg::S_DN_R;
        end else begin
          if (state_r == ihq_pkg::S_DN_L) begin
            child = hrd;
          end else if (ihq_pkg::val_less(left_r.value, hrd.value)) begin
            child     = hrd;
            child_idx = HA'(k2) + 1'b1;
          end
          if (ihq_pkg::val_less(e_r.value, child.value)) begin
            // lift the larger child into the hole
            hw_en     = 1'b1;
            hw_data   = child;
            pw_en     = 1'b1;
            pw_addr   = PA'(child.key);
            k_nxt     = child_idx;
            state_nxt = ihq_pkg::S_DN_RD;
          end else begin
            hw_en     = 1'b1;
            pw_en     = 1'b1;
            state_nxt = ihq_pkg::S_TOP_RD;
          end
        end
      end

      ihq_pkg::S_TOP_RD: begin
        hr_en     = 1'b1;
        hr_addr   = HA'(1);
        state_nxt = ihq_pkg::S_TOP;
      end

      ihq_pkg::S_TOP: begin
        if (cnt_r != '0) begin
          top_k = hrd.key;
          top_v = hrd.value;
        end
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, (cnt_r == '0), ihq_pkg::CNT_W'(cnt_r), top_v, top_k,
                           res_r.value, res_r.key, found_r, status_r};
          state_nxt     = ihq_pkg::S_IDLE;
        end
      end

      default: state_nxt = ihq_pkg::S_IDLE;
    endcase
  end

  `IHQ_ASSERT(a_cnt_range, 32'(cnt_r) <= 32'(CAPACITY), "entry count beyond capacity")
  `IHQ_ASSERT_IMP(a_out_empty, out_valid_r, out_data_r[99] == (out_data_r[98:88] == '0), "is_empty disagrees with count")
  `IHQ_ASSERT_IMP(a_hole_pos, state_r == ihq_pkg::S_UP_RD || state_r == ihq_pkg::S_DN_RD, k_r != '0 && 32'(k_r) <= 32'(CAPACITY), "sift position out of heap")

endmodule
`default_nettype wire
